// ----- rtl/cmsp_pkg.sv -----
// Shared types, widths and constant tables of the color-mark static pixel classifier.
// No dependencies; every other file imports this package.
`default_nettype none

package cmsp_pkg;

  // Sample geometry
  localparam int unsigned CHANNELS  = 3;
  localparam int unsigned MAX_OLDER = 4;
  localparam int unsigned MAX_LANES = 5;

  // Arithmetic widths
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned SUM_W   = 11;  // up to five 8-bit samples
  localparam int unsigned DEV_W   = 12;  // signed n*x - S
  localparam int unsigned SQ_W    = 21;  // squared deviation
  localparam int unsigned WT_W    = 33;  // squared deviation times lane weight
  localparam int unsigned ACC_W   = 38;  // sum over all lanes and channels
  localparam int unsigned SCALE_W = 18;  // n*n*7200
  localparam int unsigned BOUND_W = 26;  // static_limit * n*n*7200

  // Lane weights 3600/k^2, newest sample first
  localparam logic [11:0] LANE_WEIGHT [MAX_LANES] = '{
    12'd3600, 12'd900, 12'd400, 12'd225, 12'd144
  };

  // Pixel classes
  typedef enum logic [1:0] {
    CLS_GREEN  = 2'd0,
    CLS_RED    = 2'd1,
    CLS_STATIC = 2'd2,
    CLS_MOVING = 2'd3
  } cls_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_WHITE  = 2'd0,
    REG_GREEN  = 2'd1,
    REG_RED    = 2'd2,
    REG_STATIC = 2'd3
  } reg_idx_t;

  // Side information that travels along the pipeline with each pixel
  typedef struct packed {
    logic               vld;
    logic               test;
    logic [PIX_W-1:0]   blue;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   red;
    cls_t               cls;
    logic [2:0]         n;
    logic [BOUND_W-1:0] bound;
  } side_t;

  // Final result of one pixel
  typedef struct packed {
    logic             vld;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    cls_t             cls;
  } res_t;

  // Right side scale of the static test: 2 * n * n * 3600
  function automatic logic [SCALE_W-1:0] bound_scale(logic [2:0] n);
    logic [SCALE_W-1:0] s;
    case (n)
      3'd1:    s = 18'd7200;
      3'd2:    s = 18'd28800;
      3'd3:    s = 18'd64800;
      3'd4:    s = 18'd115200;
      3'd5:    s = 18'd180000;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cmsp_if.sv -----
// Valid/ready channel interfaces for pixel requests and classified results.
// Depends on cmsp_pkg, which the result interface imports.
`default_nettype none

interface cmsp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cur_blue;
  logic [7:0]  cur_green;
  logic [7:0]  cur_red;
  logic [23:0] older_1;
  logic [23:0] older_2;
  logic [23:0] older_3;
  logic [23:0] older_4;
  logic [2:0]  window_count;

  modport source (
    output valid, cur_blue, cur_green, cur_red,
    output older_1, older_2, older_3, older_4, window_count,
    input  ready
  );
  modport sink (
    input  valid, cur_blue, cur_green, cur_red,
    input  older_1, older_2, older_3, older_4, window_count,
    output ready
  );
endinterface

interface cmsp_out_if;
  import cmsp_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic [1:0] pixel_class;

  modport source (
    output valid, out_blue, out_green, out_red, pixel_class,
    input  ready
  );
  modport sink (
    input  valid, out_blue, out_green, out_red, pixel_class,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/cmsp_front.sv -----
// Stage 1: color marking, class pre-decision, window sums and static bound.
// Depends on cmsp_pkg.
`default_nettype none

module cmsp_front
  import cmsp_pkg::*;
#(
  parameter int unsigned WINDOW = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [PIX_W-1:0] cur_blue,
  input  wire logic [PIX_W-1:0] cur_green,
  input  wire logic [PIX_W-1:0] cur_red,
  input  wire logic [23:0]      older [MAX_OLDER],
  input  wire logic [2:0]       window_count,
  input  wire logic [PIX_W-1:0] white_level,
  input  wire logic [PIX_W-1:0] green_level,
  input  wire logic [PIX_W-1:0] red_level,
  input  wire logic [PIX_W-1:0] static_limit,
  output logic [PIX_W-1:0]      smp_o  [WINDOW][CHANNELS],
  output logic                  mask_o [WINDOW],
  output logic [SUM_W-1:0]      sum_o  [CHANNELS],
  output side_t                 side_o
);

  logic [PIX_W-1:0] lane_smp [WINDOW][CHANNELS];
  logic [PIX_W-1:0] smp_r    [WINDOW][CHANNELS];
  logic             mask_nxt [WINDOW];
  logic             mask_r   [WINDOW];
  logic [SUM_W-1:0] sum_nxt  [CHANNELS];
  logic [SUM_W-1:0] sum_r    [CHANNELS];
  side_t            side_nxt;
  side_t            side_r;
  logic [2:0]       n_sat;
  logic             white;

  // Unpack lanes: lane 0 is the current pixel, lane i the i-th older frame
  for (genvar i = 0; i < WINDOW; i++) begin : g_lane
    if (i == 0) begin : g_cur
      assign lane_smp[i][0] = cur_blue;
      assign lane_smp[i][1] = cur_green;
      assign lane_smp[i][2] = cur_red;
    end else begin : g_old
      assign lane_smp[i][0] = older[i-1][7:0];
      assign lane_smp[i][1] = older[i-1][15:8];
      assign lane_smp[i][2] = older[i-1][23:16];
    end
  end

  // Mark colors, pick class, build window mask, sums and bound
  always_comb begin
    white = (cur_blue > white_level) && (cur_green > white_level) &&
            (cur_red > white_level);
    n_sat = (window_count > 3'(WINDOW)) ? 3'(WINDOW) : window_count;

    side_nxt.vld   = in_valid;
    side_nxt.blue  = cur_blue;
    side_nxt.green = cur_green;
    side_nxt.red   = cur_red;
    if (!white) begin
      if (cur_green > green_level) begin
        side_nxt.blue  = '0;
        side_nxt.green = '1;
        side_nxt.red   = '0;
      end else if (cur_red > red_level) begin
        side_nxt.blue  = '0;
        side_nxt.green = '0;
        side_nxt.red   = '1;
      end
    end

    // Pure green or pure red passes, marked or raw
    if (side_nxt.blue == '0 && side_nxt.green == '1 && side_nxt.red == '0) begin
      side_nxt.cls = CLS_GREEN;
    end else if (side_nxt.blue == '0 && side_nxt.green == '0 &&
                 side_nxt.red == '1) begin
      side_nxt.cls = CLS_RED;
    end else begin
      side_nxt.cls = CLS_MOVING;
    end
    side_nxt.test  = (side_nxt.cls == CLS_MOVING) && (window_count >= 3'd2);
    side_nxt.n     = n_sat;
    side_nxt.bound = BOUND_W'(static_limit) * BOUND_W'(bound_scale(n_sat));

    for (int i = 0; i < WINDOW; i++) begin
      mask_nxt[i] = (3'(i) < n_sat);
    end
    for (int c = 0; c < CHANNELS; c++) begin
      sum_nxt[c] = '0;
      for (int i = 0; i < WINDOW; i++) begin
        if (mask_nxt[i]) begin
          sum_nxt[c] = sum_nxt[c] + SUM_W'(lane_smp[i][c]);
        end
      end
    end
  end

  // Advance valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.vld <= 1'b0;
    end else if (en) begin
      side_r.vld <= side_nxt.vld;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      side_r.test  <= side_nxt.test;
      side_r.blue  <= side_nxt.blue;
      side_r.green <= side_nxt.green;
      side_r.red   <= side_nxt.red;
      side_r.cls   <= side_nxt.cls;
      side_r.n     <= side_nxt.n;
      side_r.bound <= side_nxt.bound;
      smp_r        <= lane_smp;
      mask_r       <= mask_nxt;
      sum_r        <= sum_nxt;
    end
  end

  assign smp_o  = smp_r;
  assign mask_o = mask_r;
  assign sum_o  = sum_r;
  assign side_o = side_r;

endmodule

`default_nettype wire

// ----- rtl/cmsp_var.sv -----
// Stages 2 to 4: deviation n*x - S, its square, and the lane weight product.
// Depends on cmsp_pkg.
`default_nettype none

module cmsp_var
  import cmsp_pkg::*;
#(
  parameter int unsigned WINDOW = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic [PIX_W-1:0] smp_i  [WINDOW][CHANNELS],
  input  wire logic             mask_i [WINDOW],
  input  wire logic [SUM_W-1:0] sum_i  [CHANNELS],
  input  wire side_t            side_i,
  output logic [WT_W-1:0]       wt_o   [WINDOW][CHANNELS],
  output side_t                 side_o
);

  logic        [SUM_W-1:0] prod    [WINDOW][CHANNELS];
  logic signed [DEV_W-1:0] dev_nxt [WINDOW][CHANNELS];
  logic signed [DEV_W-1:0] dev_r   [WINDOW][CHANNELS];
  logic signed [23:0]      sq_full [WINDOW][CHANNELS];
  logic        [SQ_W-1:0]  sq_r    [WINDOW][CHANNELS];
  logic        [WT_W-1:0]  wt_nxt  [WINDOW][CHANNELS];
  logic        [WT_W-1:0]  wt_r    [WINDOW][CHANNELS];
  side_t                   side2_r;
  side_t                   side3_r;
  side_t                   side4_r;

  // Form deviations, squares and weighted terms per lane and channel
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      for (int c = 0; c < CHANNELS; c++) begin
        prod[i][c] = SUM_W'(side_i.n) * SUM_W'(smp_i[i][c]);
        if (mask_i[i]) begin
          dev_nxt[i][c] = $signed({1'b0, prod[i][c]}) - $signed({1'b0, sum_i[c]});
        end else begin
          dev_nxt[i][c] = '0;
        end
        sq_full[i][c] = 24'(dev_r[i][c]) * 24'(dev_r[i][c]);
        wt_nxt[i][c]  = WT_W'(sq_r[i][c]) * WT_W'(LANE_WEIGHT[i]);
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side2_r.vld <= 1'b0;
      side3_r.vld <= 1'b0;
      side4_r.vld <= 1'b0;
    end else if (en) begin
      side2_r.vld <= side_i.vld;
      side3_r.vld <= side2_r.vld;
      side4_r.vld <= side3_r.vld;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      side2_r.test  <= side_i.test;
      side2_r.blue  <= side_i.blue;
      side2_r.green <= side_i.green;
      side2_r.red   <= side_i.red;
      side2_r.cls   <= side_i.cls;
      side2_r.n     <= side_i.n;
      side2_r.bound <= side_i.bound;
      side3_r.test  <= side2_r.test;
      side3_r.blue  <= side2_r.blue;
      side3_r.green <= side2_r.green;
      side3_r.red   <= side2_r.red;
      side3_r.cls   <= side2_r.cls;
      side3_r.n     <= side2_r.n;
      side3_r.bound <= side2_r.bound;
      side4_r.test  <= side3_r.test;
      side4_r.blue  <= side3_r.blue;
      side4_r.green <= side3_r.green;
      side4_r.red   <= side3_r.red;
      side4_r.cls   <= side3_r.cls;
      side4_r.n     <= side3_r.n;
      side4_r.bound <= side3_r.bound;
      dev_r <= dev_nxt;
      for (int i = 0; i < WINDOW; i++) begin
        for (int c = 0; c < CHANNELS; c++) begin
          sq_r[i][c] <= sq_full[i][c][SQ_W-1:0];
        end
      end
      wt_r <= wt_nxt;
    end
  end

  assign wt_o   = wt_r;
  assign side_o = side4_r;

endmodule

`default_nettype wire

// ----- rtl/cmsp_decide.sv -----
// Stages 5 and 6: per-channel sums, total, static compare and result register.
// Depends on cmsp_pkg.
`default_nettype none

module cmsp_decide
  import cmsp_pkg::*;
#(
  parameter int unsigned WINDOW = 5
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic [WT_W-1:0] wt_i [WINDOW][CHANNELS],
  input  wire side_t           side_i,
  output res_t                 res_o
);

  logic [ACC_W-1:0] csum_nxt [CHANNELS];
  logic [ACC_W-1:0] csum_r   [CHANNELS];
  logic [ACC_W-1:0] total;
  side_t            side5_r;
  res_t             res_nxt;
  res_t             res_r;

  // Sum lanes per channel, then total and compare
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      csum_nxt[c] = '0;
      for (int i = 0; i < WINDOW; i++) begin
        csum_nxt[c] = csum_nxt[c] + ACC_W'(wt_i[i][c]);
      end
    end
    total = csum_r[0] + csum_r[1] + csum_r[2];

    res_nxt.vld   = side5_r.vld;
    res_nxt.blue  = side5_r.blue;
    res_nxt.green = side5_r.green;
    res_nxt.red   = side5_r.red;
    res_nxt.cls   = side5_r.cls;
    if (side5_r.test && (total < ACC_W'(side5_r.bound))) begin
      res_nxt.blue  = '1;
      res_nxt.green = '0;
      res_nxt.red   = '0;
      res_nxt.cls   = CLS_STATIC;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side5_r.vld <= 1'b0;
      res_r.vld   <= 1'b0;
    end else if (en) begin
      side5_r.vld <= side_i.vld;
      res_r.vld   <= res_nxt.vld;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      side5_r.test  <= side_i.test;
      side5_r.blue  <= side_i.blue;
      side5_r.green <= side_i.green;
      side5_r.red   <= side_i.red;
      side5_r.cls   <= side_i.cls;
      side5_r.n     <= side_i.n;
      side5_r.bound <= side_i.bound;
      csum_r        <= csum_nxt;
      res_r.blue    <= res_nxt.blue;
      res_r.green   <= res_nxt.green;
      res_r.red     <= res_nxt.red;
      res_r.cls     <= res_nxt.cls;
    end
  end

  assign res_o = res_r;

endmodule

`default_nettype wire

// ----- rtl/color_mark_static_pixel_classifier.sv -----
// Top level of the color-mark static pixel classifier: config registers,
// stall control and the six-stage pipeline. Depends on cmsp_pkg, cmsp_if.sv,
// cmsp_front, cmsp_var and cmsp_decide.
//
//   channel   direction  handshake         payload
//   in_px     sink       valid/ready       cur_blue/green/red, older_1..4, window_count
//   out_px    source     valid/ready       out_blue/green/red, pixel_class
//   cfg_*     sink       cfg_we            cfg_idx, cfg_wdata
//
// One pixel request per cycle while no result is stalled; each accepted request
// passes the six pipeline register stages in order (marking/sums, deviation,
// square, weight, channel sums, compare/result).
// Reset clears the valid bits of all stages and loads the register defaults.
// A stalled result holds the whole pipeline; in_px.ready drops only while
// out_px holds a result that is not taken.
`default_nettype none

module color_mark_static_pixel_classifier
  import cmsp_pkg::*;
#(
  parameter int unsigned WINDOW = 5
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  cmsp_in_if.sink         in_px,
  cmsp_out_if.source      out_px,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_idx,
  input  wire logic [7:0] cfg_wdata
);

  logic [PIX_W-1:0] white_level_r;
  logic [PIX_W-1:0] green_level_r;
  logic [PIX_W-1:0] red_level_r;
  logic [PIX_W-1:0] static_limit_r;
  logic             en;
  logic [23:0]      older [MAX_OLDER];
  logic [PIX_W-1:0] smp1  [WINDOW][CHANNELS];
  logic             mask1 [WINDOW];
  logic [SUM_W-1:0] sum1  [CHANNELS];
  side_t            side1;
  logic [WT_W-1:0]  wt4   [WINDOW][CHANNELS];
  side_t            side4;
  res_t             res;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_level_r  <= 8'd180;
      green_level_r  <= 8'd200;
      red_level_r    <= 8'd180;
      static_limit_r <= 8'd15;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_WHITE:  white_level_r  <= cfg_wdata;
        REG_GREEN:  green_level_r  <= cfg_wdata;
        REG_RED:    red_level_r    <= cfg_wdata;
        REG_STATIC: static_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance the pipeline unless the result register holds an untaken result
  assign en          = !res.vld || out_px.ready;
  assign in_px.ready = en;

  assign older[0] = in_px.older_1;
  assign older[1] = in_px.older_2;
  assign older[2] = in_px.older_3;
  assign older[3] = in_px.older_4;

  cmsp_front #(.WINDOW(WINDOW)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_px.valid),
    .cur_blue     (in_px.cur_blue),
    .cur_green    (in_px.cur_green),
    .cur_red      (in_px.cur_red),
    .older        (older),
    .window_count (in_px.window_count),
    .white_level  (white_level_r),
    .green_level  (green_level_r),
    .red_level    (red_level_r),
    .static_limit (static_limit_r),
    .smp_o        (smp1),
    .mask_o       (mask1),
    .sum_o        (sum1),
    .side_o       (side1)
  );

  cmsp_var #(.WINDOW(WINDOW)) u_var (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .smp_i  (smp1),
    .mask_i (mask1),
    .sum_i  (sum1),
    .side_i (side1),
    .wt_o   (wt4),
    .side_o (side4)
  );

  cmsp_decide #(.WINDOW(WINDOW)) u_decide (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .wt_i   (wt4),
    .side_i (side4),
    .res_o  (res)
  );

  // Drive the result channel
  assign out_px.valid       = res.vld;
  assign out_px.out_blue    = res.blue;
  assign out_px.out_green   = res.green;
  assign out_px.out_red     = res.red;
  assign out_px.pixel_class = res.cls;

  // A held result blocks new requests
  a_stall_blocks_input: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_px.valid && !out_px.ready) |-> !in_px.ready
  ) else $error("request accepted while result stalled");

  // A static pixel is always pure blue
  a_static_is_blue: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_px.valid && out_px.pixel_class == CLS_STATIC) |->
      (out_px.out_blue == 8'd255 && out_px.out_green == 8'd0 && out_px.out_red == 8'd0)
  ) else $error("static class with non-blue pixel");

  // Nothing leaves right after reset
  a_reset_empty: assert property (
    @(posedge clk) !rst_n |=> !out_px.valid
  ) else $error("result valid after reset");

endmodule

`default_nettype wire
